### src/sprt_pkg.sv
// Types and constants shared by the shared page reference count table.
package sprt_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned REFS_W   = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 6;

  typedef enum logic {
    CMD_OPEN  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ATTACHED   = 3'd0,
    ST_CREATED    = 3'd1,
    ST_FULL       = 3'd2,
    ST_STILL_USED = 3'd3,
    ST_FREED      = 3'd4,
    ST_BAD_KEY    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FRAME_W-1:0] frame;
    logic [REFS_W-1:0]  refs;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } ctrl_sts_t;

endpackage

### src/sprt_ctrl.sv
// Controller state machine for the shared page reference count table.
module sprt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  sprt_pkg::ctrl_sts_t sts,
  output sprt_pkg::ctrl_cmd_t ctrl_cmd
);

  sprt_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sprt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sprt_pkg::S_IDLE: begin
        if (start) begin
          state_next = sprt_pkg::S_SCAN;
        end
      end
      sprt_pkg::S_SCAN: begin
        if (sts.scan_last) begin
          state_next = sprt_pkg::S_DRAIN;
        end
      end
      sprt_pkg::S_DRAIN: begin
        state_next = sprt_pkg::S_DECIDE;
      end
      sprt_pkg::S_DECIDE: begin
        state_next = sprt_pkg::S_IDLE;
      end
      default: begin
        state_next = sprt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    ctrl_cmd.load   = 1'b0;
    ctrl_cmd.scan   = 1'b0;
    ctrl_cmd.commit = 1'b0;
    unique case (state)
      sprt_pkg::S_IDLE: begin
        busy          = 1'b0;
        ctrl_cmd.load = start;
      end
      sprt_pkg::S_SCAN: begin
        ctrl_cmd.scan = 1'b1;
      end
      sprt_pkg::S_DRAIN: begin
      end
      sprt_pkg::S_DECIDE: begin
        ctrl_cmd.commit = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/sprt_datapath.sv
// Datapath of the shared page reference count table: entry memory, scan and update.
module sprt_datapath #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PAGE_SHIFT    = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  sprt_pkg::ctrl_cmd_t             ctrl_cmd,
  output sprt_pkg::ctrl_sts_t             sts,
  input  logic                            cmd,
  input  logic [sprt_pkg::KEY_W-1:0]      key_id,
  input  logic [sprt_pkg::FRAME_W-1:0]    new_frame,
  input  logic [sprt_pkg::SIZE_W-1:0]     proc_size,
  output logic                            done,
  output logic [sprt_pkg::STATUS_W-1:0]   status,
  output logic [sprt_pkg::SLOT_W-1:0]     slot,
  output logic [sprt_pkg::FRAME_W-1:0]    frame_out,
  output logic [sprt_pkg::SIZE_W-1:0]     map_addr,
  output logic [sprt_pkg::REFS_W-1:0]     ref_count
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [sprt_pkg::SIZE_W-1:0] PageMask =
    sprt_pkg::SIZE_W'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [sprt_pkg::REFS_W-1:0] RefsMax = '1;

  // Request word held for the whole operation.
  logic                         req_cmd;
  logic [sprt_pkg::KEY_W-1:0]   req_key;
  logic [sprt_pkg::FRAME_W-1:0] req_frame;
  logic [sprt_pkg::SIZE_W-1:0]  req_size;

  // Entry store; an entry whose valid bit is clear is free.
  sprt_pkg::entry_t        mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;

  logic [IDX_W-1:0]  idx;
  sprt_pkg::entry_t  rd_entry;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic              cmp_en;

  logic                         hit_found;
  logic [IDX_W-1:0]             hit_idx;
  logic [sprt_pkg::FRAME_W-1:0] hit_frame;
  logic [sprt_pkg::REFS_W-1:0]  hit_refs;
  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;

  logic                         wr_en;
  logic [IDX_W-1:0]             wr_idx;
  sprt_pkg::entry_t             wr_entry;
  logic                         valid_set;
  logic                         valid_clr;
  sprt_pkg::status_t            res_status;
  logic [IDX_W-1:0]             res_idx;
  logic [sprt_pkg::FRAME_W-1:0] res_frame;
  logic [sprt_pkg::SIZE_W-1:0]  res_addr;
  logic [sprt_pkg::REFS_W-1:0]  res_refs;
  logic [sprt_pkg::REFS_W-1:0]  refs_inc;
  logic [sprt_pkg::REFS_W-1:0]  refs_dec;
  logic [sprt_pkg::SIZE_W-1:0]  rounded;

  assign sts.scan_last = (idx == LastIdx);

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      req_cmd   <= cmd;
      req_key   <= key_id;
      req_frame <= new_frame;
      req_size  <= proc_size;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.load) begin
      idx <= '0;
    end else if (ctrl_cmd.scan) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.scan) begin
      rd_entry <= mem[idx];
      rd_valid <= valid[idx];
      rd_idx   <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (valid_set) begin
      valid[wr_idx] <= 1'b1;
    end else if (valid_clr) begin
      valid[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_en <= 1'b0;
    end else begin
      cmp_en <= ctrl_cmd.scan;
    end
  end

  // The first match and the first free entry are kept as the scan goes by.
  always_ff @(posedge clk) begin
    if (rst || ctrl_cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (cmp_en) begin
      if (!hit_found && rd_valid && (rd_entry.key == req_key)) begin
        hit_found <= 1'b1;
      end
      if (!free_found && !rd_valid) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (!hit_found && rd_valid && (rd_entry.key == req_key)) begin
        hit_idx   <= rd_idx;
        hit_frame <= rd_entry.frame;
        hit_refs  <= rd_entry.refs;
      end
      if (!free_found && !rd_valid) begin
        free_idx <= rd_idx;
      end
    end
  end

  assign refs_inc = (hit_refs == RefsMax) ? hit_refs : hit_refs + sprt_pkg::REFS_W'(1);
  assign refs_dec = (hit_refs != '0) ? hit_refs - sprt_pkg::REFS_W'(1) : '0;
  assign rounded  = (req_size + PageMask) & ~PageMask;

  always_comb begin
    wr_en      = 1'b0;
    wr_idx     = hit_idx;
    wr_entry   = '{key: req_key, frame: hit_frame, refs: refs_inc};
    valid_set  = 1'b0;
    valid_clr  = 1'b0;
    res_status = sprt_pkg::ST_BAD_KEY;
    res_idx    = '0;
    res_frame  = '0;
    res_addr   = '0;
    res_refs   = '0;
    if (req_key == '0) begin
      res_status = sprt_pkg::ST_BAD_KEY;
    end else if (req_cmd == sprt_pkg::CMD_OPEN) begin
      if (hit_found) begin
        wr_en      = 1'b1;
        res_status = sprt_pkg::ST_ATTACHED;
        res_idx    = hit_idx;
        res_frame  = hit_frame;
        res_addr   = rounded;
        res_refs   = refs_inc;
      end else if (free_found) begin
        wr_en      = 1'b1;
        valid_set  = 1'b1;
        wr_idx     = free_idx;
        wr_entry   = '{key: req_key, frame: req_frame, refs: sprt_pkg::REFS_W'(1)};
        res_status = sprt_pkg::ST_CREATED;
        res_idx    = free_idx;
        res_frame  = req_frame;
        res_addr   = rounded;
        res_refs   = sprt_pkg::REFS_W'(1);
      end else begin
        res_status = sprt_pkg::ST_FULL;
      end
    end else begin
      if (!hit_found) begin
        res_status = sprt_pkg::ST_BAD_KEY;
      end else if (refs_dec == '0) begin
        valid_clr  = 1'b1;
        res_status = sprt_pkg::ST_FREED;
        res_idx    = hit_idx;
      end else begin
        wr_en      = 1'b1;
        wr_entry   = '{key: req_key, frame: hit_frame, refs: refs_dec};
        res_status = sprt_pkg::ST_STILL_USED;
        res_idx    = hit_idx;
        res_refs   = refs_dec;
      end
    end
    if (!ctrl_cmd.commit) begin
      wr_en     = 1'b0;
      valid_set = 1'b0;
      valid_clr = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_cmd.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_cmd.commit) begin
      status    <= res_status;
      slot      <= sprt_pkg::SLOT_W'(res_idx);
      frame_out <= res_frame;
      map_addr  <= res_addr;
      ref_count <= res_refs;
    end
  end

endmodule

### src/shared_page_refcount_table_top.sv
// Top level of the shared page reference count table.
//
// Each request reads the entry memory one entry a cycle to find the key and
// the lowest free entry; the drain state then finishes the last compare, and
// the decide state updates the entry and registers the result. The result
// word appears for one cycle with done high, and it cannot be held off; busy
// is already low in that cycle, so a new request may start alongside it. The
// table is empty straight after reset.
module shared_page_refcount_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned PAGE_SHIFT    = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [sprt_pkg::KEY_W-1:0]    key_id,
  input  logic [sprt_pkg::FRAME_W-1:0]  new_frame,
  input  logic [sprt_pkg::SIZE_W-1:0]   proc_size,
  output logic                          done,
  output logic [sprt_pkg::STATUS_W-1:0] status,
  output logic [sprt_pkg::SLOT_W-1:0]   slot,
  output logic [sprt_pkg::FRAME_W-1:0]  frame_out,
  output logic [sprt_pkg::SIZE_W-1:0]   map_addr,
  output logic [sprt_pkg::REFS_W-1:0]   ref_count
);

  sprt_pkg::ctrl_cmd_t ctrl_cmd;
  sprt_pkg::ctrl_sts_t ctrl_sts;

  sprt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .sts      (ctrl_sts),
    .ctrl_cmd (ctrl_cmd)
  );

  sprt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .PAGE_SHIFT    (PAGE_SHIFT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl_cmd  (ctrl_cmd),
    .sts       (ctrl_sts),
    .cmd       (cmd),
    .key_id    (key_id),
    .new_frame (new_frame),
    .proc_size (proc_size),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .frame_out (frame_out),
    .map_addr  (map_addr),
    .ref_count (ref_count)
  );

endmodule
